### hw/rtl/edi_tok_pkg.sv
// Shared types, constants and helpers of the EDI segment tokenizer.
package edi_tok_pkg;

  localparam int MAX_ELEMENTS  = 32;
  localparam int POSITION_BITS = 16;
  localparam int TAG_BYTES     = 4;

  localparam int ELEM_LIMIT = (MAX_ELEMENTS - 1) < 31 ? (MAX_ELEMENTS - 1) : 31;
  localparam int ELEM_BITS  = 5;
  localparam int OUT_POS_BITS = 16;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  localparam logic [POSITION_BITS-1:0] POS_MAX = '1;
  localparam logic [POSITION_BITS-1:0] POS_CAP = POSITION_BITS'(32'h0000_FFFF);

  // Configuration register indexes
  localparam logic [2:0] REG_ELEM_DELIM  = 3'd0;
  localparam logic [2:0] REG_SUB_DELIM   = 3'd1;
  localparam logic [2:0] REG_SEG_DELIM   = 3'd2;
  localparam logic [2:0] REG_ESC_ENABLE  = 3'd3;
  localparam logic [2:0] REG_ESC_BYTE    = 3'd4;
  localparam logic [2:0] REG_TARGET_TAG  = 3'd5;

  // Event kinds
  localparam logic [1:0] KIND_ELEM    = 2'd0;
  localparam logic [1:0] KIND_SUB     = 2'd1;
  localparam logic [1:0] KIND_SEG_END = 2'd2;
  localparam logic [1:0] KIND_EOS     = 2'd3;

  typedef struct packed {
    logic [7:0]  elem_delim;
    logic [7:0]  sub_delim;
    logic [7:0]  seg_delim;
    logic        esc_enable;
    logic [7:0]  esc_byte;
    logic [31:0] target_tag;
  } cfg_t;

  // One accepted byte's worth of events: a delimiter event and/or a stream end.
  typedef struct packed {
    logic                     ev0_valid;
    logic [1:0]               ev0_kind;
    logic [ELEM_BITS-1:0]     ev0_elem;
    logic [ELEM_BITS-1:0]     ev0_sub;
    logic                     ev1_valid;
    logic [ELEM_BITS-1:0]     count;
    logic [31:0]              tag;
    logic [OUT_POS_BITS-1:0]  pos;
    logic                     match;
    logic                     overflow;
  } rec_t;

  typedef struct packed {
    logic [1:0]              kind;
    logic [31:0]             tag;
    logic [OUT_POS_BITS-1:0] pos;
    logic [ELEM_BITS-1:0]    elem;
    logic [ELEM_BITS-1:0]    sub;
    logic                    match;
    logic                    overflow;
    logic                    last;
  } event_t;

  function automatic logic [OUT_POS_BITS-1:0] cap_pos(input logic [POSITION_BITS-1:0] p);
    logic [OUT_POS_BITS-1:0] r;
    if (p > POS_CAP) r = '1;
    else             r = OUT_POS_BITS'(p);
    return r;
  endfunction

endpackage

### hw/rtl/edi_segment_tokenizer.sv
// Top level of the EDI segment tokenizer: config registers, front, queue, back.
//
// Input stream s_*: one EDI byte per request in s_tdata, s_tlast marks the
// final byte of the stream. Output stream m_*: one event per request, the
// event kind in m_tuser, m_tlast on the last event caused by an input byte.
// A byte may cause no event, one event, or two (a delimiter event and a
// stream-end event).
// Throughput: one byte per cycle while the record queue is not full. A byte
// causing two events holds the output for both in turn; the four-entry
// record queue absorbs such bursts. An event reaches m_* by way of the front
// end's write into the queue and then the back end's output register.
// When m_tready is low the output register holds its event, the queue
// fills, and s_tready drops only once four records are waiting.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect on the next
// edge. The user must make them only while the block is idle; the block
// itself does not enforce this.
// Reset clears the segment state, empties the queue and restores the
// default delimiters ('*', ':', '~'), escaping off and a zero target tag.
module edi_segment_tokenizer (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // [31:0] segment_tag, [47:32] position,
                                 // [52:48] element_number, [57:53] subelement_number,
                                 // [58] tag_match, [59] element_overflow, [63:60] zero
  output logic [1:0]  m_tuser,   // [1:0] event_kind
  output logic        m_tlast
);
  import edi_tok_pkg::*;

  cfg_t   cfg;
  rec_t   rec, head;
  event_t out_event;
  logic   push, pop, q_empty, q_full, accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.elem_delim <= 8'd42;
      cfg.sub_delim  <= 8'd58;
      cfg.seg_delim  <= 8'd126;
      cfg.esc_enable <= 1'b0;
      cfg.esc_byte   <= 8'd0;
      cfg.target_tag <= 32'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ELEM_DELIM: cfg.elem_delim <= cfg_data[7:0];
        REG_SUB_DELIM:  cfg.sub_delim  <= cfg_data[7:0];
        REG_SEG_DELIM:  cfg.seg_delim  <= cfg_data[7:0];
        REG_ESC_ENABLE: cfg.esc_enable <= cfg_data[0];
        REG_ESC_BYTE:   cfg.esc_byte   <= cfg_data[7:0];
        REG_TARGET_TAG: cfg.target_tag <= cfg_data;
        default: ;
      endcase
    end
  end

  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;

  edi_tok_front u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .accept        (accept),
    .data_byte     (s_tdata),
    .end_of_stream (s_tlast),
    .push          (push),
    .rec           (rec)
  );

  edi_tok_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (rec),
    .pop   (pop),
    .rdata (head),
    .empty (q_empty),
    .full  (q_full)
  );

  edi_tok_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .q_empty   (q_empty),
    .pop       (pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_event (out_event)
  );

  assign m_tdata = {4'b0000, out_event.overflow, out_event.match, out_event.sub,
                    out_event.elem, out_event.pos, out_event.tag};
  assign m_tuser = out_event.kind;
  assign m_tlast = out_event.last;

endmodule

### hw/rtl/edi_tok_front.sv
// Front end: classifies each byte, tracks segment state and builds event records.
module edi_tok_front (
  input  logic                clk,
  input  logic                rst,
  input  edi_tok_pkg::cfg_t   cfg,
  input  logic                accept,
  input  logic [7:0]          data_byte,
  input  logic                end_of_stream,
  output logic                push,
  output edi_tok_pkg::rec_t   rec
);
  import edi_tok_pkg::*;

  logic [2:0]               tag_byte_count, tag_byte_count_next;
  logic                     tag_done, tag_done_next;
  logic [31:0]              tag_value, tag_value_next;
  logic [POSITION_BITS-1:0] byte_position, byte_position_next;
  logic [ELEM_BITS-1:0]     element_count, element_count_next;
  logic [ELEM_BITS-1:0]     subelement_count, subelement_count_next;
  logic                     escape_pending, escape_pending_next;
  logic                     overflow_seen, overflow_seen_next;

  logic consumed, ended;

  always_comb begin
    tag_byte_count_next   = tag_byte_count;
    tag_done_next         = tag_done;
    tag_value_next        = tag_value;
    byte_position_next    = byte_position;
    element_count_next    = element_count;
    subelement_count_next = subelement_count;
    escape_pending_next   = escape_pending;
    overflow_seen_next    = overflow_seen;
    consumed              = 1'b0;
    ended                 = 1'b0;
    rec                   = '0;

    // Tag collection: only element and segment delimiters close it early
    if (!tag_done) begin
      if (data_byte == cfg.elem_delim || data_byte == cfg.seg_delim) begin
        tag_done_next = 1'b1;
      end else begin
        case (tag_byte_count[1:0])
          2'd0:    tag_value_next[7:0]   = data_byte;
          2'd1:    tag_value_next[15:8]  = data_byte;
          2'd2:    tag_value_next[23:16] = data_byte;
          default: tag_value_next[31:24] = data_byte;
        endcase
        tag_byte_count_next = tag_byte_count + 3'd1;
        if (tag_byte_count_next >= 3'(TAG_BYTES)) tag_done_next = 1'b1;
        consumed = 1'b1;
      end
    end

    if (!consumed) begin
      if (escape_pending) begin
        escape_pending_next = 1'b0;
      end else if (cfg.esc_enable && data_byte == cfg.esc_byte) begin
        escape_pending_next = 1'b1;
      end else if (data_byte == cfg.elem_delim) begin
        if (element_count < ELEM_BITS'(ELEM_LIMIT)) begin
          rec.ev0_valid         = 1'b1;
          rec.ev0_kind          = KIND_ELEM;
          rec.ev0_elem          = element_count;
          element_count_next    = element_count + 1'b1;
          subelement_count_next = ELEM_BITS'(1);
        end else begin
          overflow_seen_next = 1'b1;
        end
      end else if (data_byte == cfg.seg_delim) begin
        rec.ev0_valid = 1'b1;
        rec.ev0_kind  = KIND_SEG_END;
        rec.ev0_elem  = element_count;
        ended         = 1'b1;
      end else if (data_byte == cfg.sub_delim && element_count != '0 &&
                   !overflow_seen && subelement_count != '0) begin
        rec.ev0_valid = 1'b1;
        rec.ev0_kind  = KIND_SUB;
        rec.ev0_elem  = element_count - 1'b1;
        rec.ev0_sub   = subelement_count;
        if (subelement_count >= ELEM_BITS'(ELEM_LIMIT)) subelement_count_next = '0;
        else subelement_count_next = subelement_count + 1'b1;
      end
    end

    // Fields shared by both events, taken before any segment clear
    rec.ev1_valid = end_of_stream && !ended;
    rec.count     = element_count_next;
    rec.tag       = tag_value_next;
    rec.pos       = cap_pos(byte_position);
    rec.match     = (tag_value_next == cfg.target_tag);
    rec.overflow  = overflow_seen_next;

    if (byte_position != POS_MAX) byte_position_next = byte_position + 1'b1;

    if (ended || end_of_stream) begin
      tag_byte_count_next   = '0;
      tag_done_next         = 1'b0;
      tag_value_next        = '0;
      byte_position_next    = '0;
      element_count_next    = '0;
      subelement_count_next = ELEM_BITS'(1);
      escape_pending_next   = 1'b0;
      overflow_seen_next    = 1'b0;
    end
  end

  assign push = accept && (rec.ev0_valid || rec.ev1_valid);

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_byte_count   <= '0;
      tag_done         <= 1'b0;
      tag_value        <= '0;
      byte_position    <= '0;
      element_count    <= '0;
      subelement_count <= ELEM_BITS'(1);
      escape_pending   <= 1'b0;
      overflow_seen    <= 1'b0;
    end else if (accept) begin
      tag_byte_count   <= tag_byte_count_next;
      tag_done         <= tag_done_next;
      tag_value        <= tag_value_next;
      byte_position    <= byte_position_next;
      element_count    <= element_count_next;
      subelement_count <= subelement_count_next;
      escape_pending   <= escape_pending_next;
      overflow_seen    <= overflow_seen_next;
    end
  end

`ifndef ASSERT_OFF
  a_tag_before_elements: assert property (@(posedge clk) disable iff (rst)
    !tag_done |-> element_count == '0)
    else $error("element counted while tag still open");
  a_overflow_at_limit: assert property (@(posedge clk) disable iff (rst)
    overflow_seen |-> element_count == ELEM_BITS'(ELEM_LIMIT))
    else $error("overflow flagged below element limit");
  a_sub_reset: assert property (@(posedge clk) disable iff (rst)
    element_count == '0 |-> subelement_count == ELEM_BITS'(1))
    else $error("sub-element count moved before first element");
`endif

endmodule

### hw/rtl/edi_tok_queue.sv
// Short record queue between front and back ends.
module edi_tok_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  edi_tok_pkg::rec_t wdata,
  input  logic              pop,
  output edi_tok_pkg::rec_t rdata,
  output logic              empty,
  output logic              full
);
  import edi_tok_pkg::*;

  rec_t                entries [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr, rd_ptr;
  logic [QUEUE_AW:0]   count;

  assign empty = (count == '0);
  assign full  = (count == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign rdata = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) entries[wr_ptr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) wr_ptr <= wr_ptr + 1'b1;
      if (pop && !empty) rd_ptr <= rd_ptr + 1'b1;
      count <= count + (QUEUE_AW+1)'(push && !full) - (QUEUE_AW+1)'(pop && !empty);
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (QUEUE_AW+1)'(QUEUE_DEPTH))
    else $error("queue count beyond depth");
`endif

endmodule

### hw/rtl/edi_tok_back.sv
// Back end: splits queued records into events and holds them in an output register.
module edi_tok_back (
  input  logic                clk,
  input  logic                rst,
  input  edi_tok_pkg::rec_t   head,
  input  logic                q_empty,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output edi_tok_pkg::event_t out_event
);
  import edi_tok_pkg::*;

  logic   phase;   // 1: first event of head already sent
  logic   load;
  logic   send_first;
  event_t ev_next;

  assign load       = !q_empty && (!out_valid || out_ready);
  assign send_first = !phase && head.ev0_valid;

  always_comb begin
    ev_next          = '0;
    ev_next.tag      = head.tag;
    ev_next.pos      = head.pos;
    ev_next.overflow = head.overflow;
    if (send_first) begin
      ev_next.kind  = head.ev0_kind;
      ev_next.elem  = head.ev0_elem;
      ev_next.sub   = head.ev0_sub;
      ev_next.match = (head.ev0_kind == KIND_SEG_END) ? head.match : 1'b0;
      ev_next.last  = !head.ev1_valid;
    end else begin
      ev_next.kind  = KIND_EOS;
      ev_next.elem  = head.count;
      ev_next.match = head.match;
      ev_next.last  = 1'b1;
    end
  end

  assign pop = load && ev_next.last;

  always_ff @(posedge clk) begin
    if (load) out_event <= ev_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      phase     <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        phase     <= !ev_next.last;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef ASSERT_OFF
  a_phase_has_record: assert property (@(posedge clk) disable iff (rst)
    phase |-> !q_empty)
    else $error("second event pending with empty queue");
  a_sub_numbered: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_event.kind == KIND_SUB |-> out_event.sub != '0)
    else $error("sub-element event without number");
`endif

endmodule

### dv/edi_segment_tokenizer_tb.sv
// Self-checking testbench for the EDI segment tokenizer: byte stream in, token events out.
module edi_segment_tokenizer_tb;
  import edi_tok_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       eos;
    logic [3:0] gap;
  } stream_byte_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;

  edi_segment_tokenizer dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tlast(s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Tokenizer state mirrored by the predictor
  cfg_t                     cfg;
  logic [2:0]               tag_cnt;
  logic                     tag_closed;
  logic [31:0]              tag_acc;
  logic [POSITION_BITS-1:0] seg_pos;
  logic [4:0]               elem_cnt;
  logic [4:0]               sub_cnt;
  logic                     esc_armed;
  logic                     ovf_seen;

  stream_byte_t stream_bytes[$];
  event_t       token_events_due[$];

  int   bytes_queued = 0;
  int   bytes_accepted = 0;
  int   events_seen = 0;
  int   mismatch_count = 0;
  bit   byte_taken = 1'b0;
  bit   result_taken = 1'b0;
  bit   presenting = 1'b0;
  bit   gap_armed = 1'b0;
  int   gap_left = 0;
  int   rx_wait = 0;
  bit   rx_quiet = 1'b0;
  bit   seg_quiet = 1'b0;
  stream_byte_t next_byte;

  task automatic report_mismatch(input string what);
    $display("ERROR @%0t event %0d: %s", $time, events_seen, what);
    mismatch_count++;
  endtask

  task automatic clear_segment();
    tag_cnt    = '0;
    tag_closed = 1'b0;
    tag_acc    = '0;
    seg_pos    = '0;
    elem_cnt   = '0;
    sub_cnt    = 5'd1;
    esc_armed  = 1'b0;
    ovf_seen   = 1'b0;
  endtask

  function automatic event_t make_event(input logic [1:0] kind,
                                        input logic [POSITION_BITS-1:0] p,
                                        input logic [4:0] elem, input logic [4:0] sub,
                                        input logic hit);
    event_t ev;
    ev.kind     = kind;
    ev.tag      = tag_acc;
    ev.pos      = (32'(p) > 32'hFFFF) ? 16'hFFFF : 16'(p);
    ev.elem     = elem;
    ev.sub      = sub;
    ev.match    = hit;
    ev.overflow = ovf_seen;
    ev.last     = 1'b0;
    return ev;
  endfunction

  // Work out the events one accepted byte causes and queue them in order.
  task automatic tokenize_byte(input logic [7:0] c, input logic eos);
    logic [POSITION_BITS-1:0] pos_now;
    logic   consumed;
    logic   ended;
    event_t evs[2];
    int     n;
    pos_now  = seg_pos;
    consumed = 1'b0;
    ended    = 1'b0;
    n        = 0;
    if (!tag_closed) begin
      if (c == cfg.elem_delim || c == cfg.seg_delim) begin
        tag_closed = 1'b1;
      end else begin
        tag_acc  = tag_acc | (32'(c) << (8 * tag_cnt[1:0]));
        tag_cnt  = tag_cnt + 3'd1;
        if (tag_cnt >= 3'd4) tag_closed = 1'b1;
        consumed = 1'b1;
      end
    end
    if (!consumed) begin
      if (esc_armed) begin
        esc_armed = 1'b0;
      end else if (cfg.esc_enable && c == cfg.esc_byte) begin
        esc_armed = 1'b1;
      end else if (c == cfg.elem_delim) begin
        if (int'(elem_cnt) < ELEM_LIMIT) begin
          evs[n] = make_event(KIND_ELEM, pos_now, elem_cnt, 5'd0, 1'b0);
          n++;
          elem_cnt = elem_cnt + 5'd1;
          sub_cnt  = 5'd1;
        end else begin
          ovf_seen = 1'b1;
        end
      end else if (c == cfg.seg_delim) begin
        evs[n] = make_event(KIND_SEG_END, pos_now, elem_cnt, 5'd0, tag_acc == cfg.target_tag);
        n++;
        clear_segment();
        ended = 1'b1;
      end else if (c == cfg.sub_delim && elem_cnt != 0 && !ovf_seen && sub_cnt != 0) begin
        evs[n] = make_event(KIND_SUB, pos_now, elem_cnt - 5'd1, sub_cnt, 1'b0);
        n++;
        // park the counter at zero once the per-element limit is reached
        if (int'(sub_cnt) >= ELEM_LIMIT) sub_cnt = 5'd0;
        else sub_cnt = sub_cnt + 5'd1;
      end
    end
    if (!ended && seg_pos != POS_MAX) seg_pos = seg_pos + 1'b1;
    if (eos) begin
      if (!ended) begin
        evs[n] = make_event(KIND_EOS, pos_now, elem_cnt, 5'd0, tag_acc == cfg.target_tag);
        n++;
      end
      clear_segment();
    end
    if (n > 0) evs[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) token_events_due.push_back(evs[i]);
  endtask

  task automatic compare_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %h want %h", name, got, want));
  endtask

  // Result side first: a byte's events never show up on the edge that accepts it.
  always @(posedge clk) begin
    event_t want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        result_taken = 1'b1;
        if (token_events_due.size() == 0) begin
          report_mismatch($sformatf("unexpected event kind %0d data %h", m_tuser, m_tdata));
        end else begin
          want = token_events_due.pop_front();
          compare_field("event_kind", 32'(m_tuser), 32'(want.kind));
          compare_field("segment_tag", m_tdata[31:0], want.tag);
          compare_field("position", 32'(m_tdata[47:32]), 32'(want.pos));
          compare_field("element_number", 32'(m_tdata[52:48]), 32'(want.elem));
          compare_field("subelement_number", 32'(m_tdata[57:53]), 32'(want.sub));
          compare_field("tag_match", 32'(m_tdata[58]), 32'(want.match));
          compare_field("element_overflow", 32'(m_tdata[59]), 32'(want.overflow));
          compare_field("pad", 32'(m_tdata[63:60]), 32'd0);
          compare_field("last", 32'(m_tlast), 32'(want.last));
        end
        events_seen++;
      end
      if (s_tvalid && s_tready) begin
        tokenize_byte(s_tdata, s_tlast);
        bytes_accepted++;
        byte_taken = 1'b1;
      end
    end
  end

  // Byte sender: hold each request until taken, then idle for the next item's gap.
  always @(negedge clk) begin
    if (!rst) begin
      if (byte_taken) begin
        byte_taken = 1'b0;
        presenting = 1'b0;
      end
      if (!presenting && stream_bytes.size() > 0) begin
        if (!gap_armed) begin
          next_byte = stream_bytes[0];
          gap_left  = next_byte.gap;
          gap_armed = 1'b1;
        end
        if (gap_left > 0) begin
          gap_left--;
        end else begin
          next_byte  = stream_bytes.pop_front();
          gap_armed  = 1'b0;
          presenting = 1'b1;
          s_tdata <= next_byte.data;
          s_tlast <= next_byte.eos;
        end
      end
      s_tvalid <= presenting;
    end
  end

  // Event receiver: stall a random number of cycles after each taken event unless rx_quiet is set.
  always @(negedge clk) begin
    if (!rst) begin
      if (result_taken) begin
        result_taken = 1'b0;
        rx_wait = rx_quiet ? 0 : $urandom_range(0, 8);
      end
      if (rx_wait > 0) begin
        rx_wait--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  task automatic send(input logic [7:0] b, input logic eos);
    stream_byte_t item;
    item.data = b;
    item.eos  = eos;
    item.gap  = seg_quiet ? 4'd0 : 4'($urandom_range(0, 8));
    stream_bytes.push_back(item);
    bytes_queued++;
  endtask

  task automatic send_text(input string s, input logic eos_on_last);
    for (int i = 0; i < s.len(); i++) send(s[i], eos_on_last && i == s.len() - 1);
  endtask

  function automatic logic [7:0] tag_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    while (b == cfg.elem_delim || b == cfg.seg_delim) b = 8'($urandom_range(0, 255));
    return b;
  endfunction

  function automatic logic [7:0] content_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    while (b == cfg.elem_delim || b == cfg.seg_delim || b == cfg.sub_delim ||
           (cfg.esc_enable && b == cfg.esc_byte))
      b = 8'($urandom_range(0, 255));
    return b;
  endfunction

  function automatic logic [7:0] hidden_byte();
    logic [7:0] b;
    case ($urandom_range(0, 4))
      0: b = cfg.elem_delim;
      1: b = cfg.seg_delim;
      2: b = cfg.sub_delim;
      3: b = cfg.esc_byte;
      default: b = 8'($urandom_range(0, 255));
    endcase
    return b;
  endfunction

  // Half the time try to spell the target tag so that segments match.
  task automatic send_tag();
    int   nb;
    logic ok;
    nb = 0;
    ok = 1'b0;
    if ($urandom_range(0, 1) == 1) begin
      ok = 1'b1;
      for (int k = 0; k < 4; k++) if (cfg.target_tag[8*k +: 8] != 8'd0) nb = k + 1;
      for (int k = 0; k < nb; k++)
        if (cfg.target_tag[8*k +: 8] == cfg.elem_delim ||
            cfg.target_tag[8*k +: 8] == cfg.seg_delim) ok = 1'b0;
    end
    if (ok) begin
      for (int k = 0; k < nb; k++) send(cfg.target_tag[8*k +: 8], 1'b0);
    end else begin
      nb = $urandom_range(0, 5);
      for (int k = 0; k < nb; k++) send(tag_byte(), 1'b0);
    end
  endtask

  task automatic send_segment(input bit big);
    int n_el;
    int n_body;
    int r;
    send_tag();
    n_el = big ? $urandom_range(30, 36) : $urandom_range(0, 5);
    for (int k = 0; k < n_el; k++) begin
      send(cfg.elem_delim, 1'b0);
      // run past the sub-element limit inside one element
      if (big && k == 1) for (int j = 0; j < 33; j++) send(cfg.sub_delim, 1'b0);
      n_body = big ? $urandom_range(0, 1) : $urandom_range(0, 6);
      for (int j = 0; j < n_body; j++) begin
        r = $urandom_range(0, 9);
        if (r < 2) begin
          send(cfg.sub_delim, 1'b0);
        end else if (r == 2) begin
          send(cfg.esc_byte, 1'b0);
          send(hidden_byte(), 1'b0);
        end else if (r == 3) begin
          send(8'($urandom_range(0, 255)), 1'b0);
        end else begin
          send(content_byte(), 1'b0);
        end
      end
    end
    if ($urandom_range(0, 14) == 0) send(content_byte(), 1'b1);
    else send(cfg.seg_delim, $urandom_range(0, 9) == 0);
  endtask

  task automatic random_phase(input int n_items, input bit with_big);
    int start;
    bit first;
    start = bytes_queued;
    first = 1'b1;
    while (bytes_queued - start < n_items) begin
      seg_quiet = ($urandom_range(0, 3) == 0);
      send_segment(first && with_big);
      first = 1'b0;
    end
    seg_quiet = 1'b0;
    // trailing noise
    repeat (6) send(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
  endtask

  task automatic wait_idle();
    while (!(bytes_accepted == bytes_queued && token_events_due.size() == 0)) @(negedge clk);
    // a byte that causes no event may still be in flight
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_ELEM_DELIM: cfg.elem_delim = val[7:0];
      REG_SUB_DELIM:  cfg.sub_delim  = val[7:0];
      REG_SEG_DELIM:  cfg.seg_delim  = val[7:0];
      REG_ESC_ENABLE: cfg.esc_enable = val[0];
      REG_ESC_BYTE:   cfg.esc_byte   = val[7:0];
      REG_TARGET_TAG: cfg.target_tag = val;
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic configure(input logic [7:0] elem, input logic [7:0] sub,
                           input logic [7:0] seg, input logic en,
                           input logic [7:0] esc, input logic [31:0] target);
    wait_idle();
    write_reg(REG_ELEM_DELIM, 32'(elem));
    write_reg(REG_SUB_DELIM, 32'(sub));
    write_reg(REG_SEG_DELIM, 32'(seg));
    write_reg(REG_ESC_ENABLE, 32'(en));
    write_reg(REG_ESC_BYTE, 32'(esc));
    write_reg(REG_TARGET_TAG, target);
    cfg_we <= 1'b0;
  endtask

  initial begin
    cfg.elem_delim = 8'd42;
    cfg.sub_delim  = 8'd58;
    cfg.seg_delim  = 8'd126;
    cfg.esc_enable = 1'b0;
    cfg.esc_byte   = 8'd0;
    cfg.target_tag = 32'd0;
    clear_segment();
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    // Reset defaults: basic segment, empty segment, long tag, extreme bytes, stream ends
    send_text("ISA*0:1:*~", 1'b0);
    send_text("~", 1'b0);
    send_text("ABCD:E*~", 1'b0);
    send(8'h00, 1'b0);
    send(8'hFF, 1'b0);
    send_text("*", 1'b0);
    send(8'hFF, 1'b0);
    send(8'h00, 1'b1);
    send_text("Q*", 1'b1);
    send_text("R~", 1'b1);
    send_text("S", 1'b1);

    configure(8'h00, 8'hFF, 8'h0A, 1'b1, 8'h5C, 32'hFFFF_FFFF);
    random_phase(60, 1'b1);

    configure(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
              8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
              8'($urandom_range(0, 255)), $urandom);
    rx_quiet = 1'b1;
    random_phase(55, 1'b0);
    rx_quiet = 1'b0;

    configure(8'hFF, 8'h00, 8'h80, 1'b0, 8'hFF, 32'h0000_5349);
    random_phase(55, 1'b0);

    // Escaping on: hidden delimiters, escape in the tag, escape left pending at stream end
    configure(8'h2A, 8'h3A, 8'h7E, 1'b1, 8'h3F, 32'h0041_5349);
    send_text("ES*?*x?~?::~", 1'b0);
    send_text("?B*?", 1'b1);
    send_text("*~", 1'b0);
    random_phase(55, 1'b0);

    // Colliding codes: escape equals element delimiter equals sub-element delimiter
    configure(8'h7C, 8'h7C, 8'h27, 1'b1, 8'h7C, 32'h0000_0000);
    random_phase(60, 1'b1);

    // Default delimiters again with a short matching tag, then a stream end
    configure(8'h2A, 8'h3A, 8'h7E, 1'b0, 8'h00, 32'h0000_4241);
    send_text("TXT*:~AB*~", 1'b0);
    send_text("Z", 1'b1);

    wait_idle();
    if (token_events_due.size() != 0)
      report_mismatch($sformatf("%0d events never arrived", token_events_due.size()));
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

### filelist.f
hw/rtl/edi_tok_pkg.sv
hw/rtl/edi_tok_front.sv
hw/rtl/edi_tok_queue.sv
hw/rtl/edi_tok_back.sv
hw/rtl/edi_segment_tokenizer.sv
dv/edi_segment_tokenizer_tb.sv
